// ===== rtl/fes_pkg.sv =====
package fes_pkg;

  localparam int unsigned MAX_DELAY_DEF = 32768;
  localparam int unsigned GAIN_FRAC_DEF = 14;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned DELAY_W   = 15;
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned CLIP_W    = 15;
  localparam int unsigned FILL_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  localparam logic [DELAY_W-1:0] DELAY_RST = DELAY_W'(1);
  localparam logic [GAIN_W-1:0]  GAIN_RST  = GAIN_W'(8192);
  localparam logic [CLIP_W-1:0]  CLIP_RST  = CLIP_W'(32767);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY = 2'd0,
    CFG_GAIN  = 2'd1,
    CFG_CLIP  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] in_sample;
    logic                       last_in;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_sample;
    logic                       clipped;
    logic                       last_out;
  } out_t;

endpackage

// ===== rtl/fes_ram.sv =====
module fes_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/fes_mix.sv =====
module fes_mix #(
  parameter int unsigned FRAC = 14
) (
  input  logic signed [fes_pkg::SAMPLE_W-1:0] x,
  input  logic signed [fes_pkg::SAMPLE_W-1:0] past,
  input  logic        [fes_pkg::GAIN_W-1:0]   gain,
  input  logic        [fes_pkg::CLIP_W-1:0]   lim,
  input  logic                                pass,
  output logic signed [fes_pkg::SAMPLE_W-1:0] y,
  output logic                                clipped
);
  import fes_pkg::*;

  localparam int unsigned TW = (((SAMPLE_W + FRAC) > 33) ? (SAMPLE_W + FRAC) : 33) + 1;
  localparam logic signed [TW-1:0] ROUND = TW'((1 << FRAC) - 1);

  logic signed [TW-1:0] prod;
  logic signed [TW-1:0] total;
  logic signed [TW-1:0] biased;
  logic signed [TW-1:0] quot;
  logic signed [TW-1:0] lim_s;

  always_comb begin
    prod   = TW'($signed({1'b0, gain})) * TW'(past);
    total  = (TW'(x) <<< FRAC) + prod;
    // bias negatives so the shift truncates toward zero
    biased = total + (total[TW-1] ? ROUND : '0);
    quot   = biased >>> FRAC;
    lim_s  = TW'(lim);
    if (pass) begin
      y       = x;
      clipped = 1'b0;
    end else if (quot > lim_s) begin
      y       = SAMPLE_W'(lim_s);
      clipped = 1'b1;
    end else if (quot < -lim_s) begin
      y       = SAMPLE_W'(-lim_s);
      clipped = 1'b1;
    end else begin
      y       = quot[SAMPLE_W-1:0];
      clipped = 1'b0;
    end
  end

endmodule

// ===== rtl/feedback_echo_saturating.sv =====
// An accepted input word passes the input register, then the result register; the delay line
// RAM reads at accept and writes as the word enters the result register. Throughput: one word
// per cycle unless results stall; a forward path from the last result serves a one-sample delay.
// A stalled result word holds; one more input word then waits in the input register.
// Synchronous active-low reset clears handshake state, position, fill count and configuration
// registers to their defaults; delay line contents are undefined until written.
module feedback_echo_saturating #(
  parameter int unsigned MAX_DELAY      = fes_pkg::MAX_DELAY_DEF,
  parameter int unsigned GAIN_FRAC_BITS = fes_pkg::GAIN_FRAC_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  fes_pkg::in_t                     in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output fes_pkg::out_t                    out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fes_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fes_pkg::CFG_DAT_W-1:0]    cfg_data
);
  import fes_pkg::*;

  localparam int unsigned AW = $clog2(MAX_DELAY);
  localparam int unsigned DW = ((AW + 1) > FILL_W) ? (AW + 1) : FILL_W;

  logic [DELAY_W-1:0] delay_r;
  logic [GAIN_W-1:0]  gain_r;
  logic [CLIP_W-1:0]  clip_r;

  logic [AW-1:0]     wpos_r, wpos_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;

  logic          s1_v_r;
  in_t           s1_data_r;
  logic          s1_pass_r;
  logic          s1_fwd_r;
  logic [AW-1:0] s1_wpos_r;

  logic                       out_v_r;
  out_t                       out_r;
  logic signed [SAMPLE_W-1:0] last_y_r;

  logic                       in_acc, s1_adv;
  logic [DW-1:0]              d_eff;
  logic [DW:0]                rdiff;
  logic [AW-1:0]              raddr;
  logic [SAMPLE_W-1:0]        rdata;
  logic signed [SAMPLE_W-1:0] past;
  logic signed [SAMPLE_W-1:0] y;
  logic                       y_clip;

  assign cfg_ready = 1'b1;
  assign s1_adv    = s1_v_r && (!out_v_r || !out_stall);
  assign in_stall  = s1_v_r && !s1_adv;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= DELAY_RST;
      gain_r  <= GAIN_RST;
      clip_r  <= CLIP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DELAY: delay_r <= cfg_data[DELAY_W-1:0];
        CFG_GAIN:  gain_r  <= cfg_data[GAIN_W-1:0];
        CFG_CLIP:  clip_r  <= cfg_data[CLIP_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp delay to [1, MAX_DELAY], find the read slot behind the write pointer, form next pos/fill
  always_comb begin
    d_eff = DW'(delay_r);
    if (d_eff == '0) begin
      d_eff = DW'(1);
    end else if (d_eff > DW'(MAX_DELAY)) begin
      d_eff = DW'(MAX_DELAY);
    end
    rdiff = {1'b0, DW'(wpos_r)} - {1'b0, d_eff};
    if (rdiff[DW]) begin
      rdiff = rdiff + (DW + 1)'(MAX_DELAY);
    end
    raddr = rdiff[AW-1:0];

    wpos_nxt = (wpos_r == AW'(MAX_DELAY - 1)) ? '0 : wpos_r + 1'b1;
    if (in_data.last_in) begin
      fill_nxt = '0;
    end else if (fill_r != '1) begin
      fill_nxt = fill_r + 1'b1;
    end else begin
      fill_nxt = fill_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpos_r  <= '0;
      fill_r  <= '0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_acc) begin
        wpos_r <= wpos_nxt;
        fill_r <= fill_nxt;
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_data;
      s1_pass_r <= DW'(fill_r) < d_eff;
      // the previous word writes its slot this same edge: take it from last_y_r
      s1_fwd_r  <= (d_eff == DW'(1)) && s1_adv;
      s1_wpos_r <= wpos_r;
    end
    if (s1_adv) begin
      out_r.out_sample <= y;
      out_r.clipped    <= y_clip;
      out_r.last_out   <= s1_data_r.last_in;
      last_y_r         <= y;
    end
  end

  fes_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_DELAY)
  ) u_line (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_wpos_r),
    .wdata (y),
    .re    (in_acc),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign past = s1_fwd_r ? last_y_r : $signed(rdata);

  fes_mix #(
    .FRAC (GAIN_FRAC_BITS)
  ) u_mix (
    .x       (s1_data_r.in_sample),
    .past    (past),
    .gain    (gain_r),
    .lim     (clip_r),
    .pass    (s1_pass_r),
    .y       (y),
    .clipped (y_clip)
  );

endmodule

// ===== rtl/fes_checker.sv =====
module fes_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input fes_pkg::out_t                 out_data
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // after an accept, through the input and result registers, the result side holds a valid word
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> ##2 out_valid)
    else $error("result missing two cycles after accept");

  // a clamped sample is never -32768, so the clamped range stays symmetric
  a_clip_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.clipped |-> out_data.out_sample != 16'sh8000)
    else $error("clamped sample outside symmetric range");

  // reset empties the result register
  a_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind feedback_echo_saturating fes_checker u_fes_checker (.*);
